// File: sv/rotary_encoder_click_decoder_core_macros.svh
// assertion macros for the encoder click decoder
`ifndef ROTARY_ENCODER_CLICK_DECODER_CORE_MACROS_SVH
`define ROTARY_ENCODER_CLICK_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define RECD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("recd assertion failed");
// next-cycle implication, disabled in reset
`define RECD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("recd assertion failed");
`else
`define RECD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RECD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/recd_pkg.sv
`default_nettype none

package recd_pkg;

    // click queue
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SETTLE_W    = 16;
    localparam int COUNT_W     = 8;
    localparam int QUEUED_W    = 5;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(1);
    localparam logic [SETTLE_W-1:0] SETTLE_MAX   = '1;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(127);
    localparam logic signed [COUNT_W-1:0] COUNT_MIN  = -COUNT_W'(127);
    localparam logic signed [COUNT_W-1:0] COUNT_UP   = COUNT_W'(1);
    localparam logic signed [COUNT_W-1:0] COUNT_DOWN = -COUNT_W'(1);

    // line debounce phases
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_SETTLE_ON  = 2'd1,
        PH_HELD       = 2'd2,
        PH_SETTLE_OFF = 2'd3
    } phase_t;

    // direction tracking
    typedef struct packed {
        logic dir_known;
        logic last_direction;
        logic last_edge_line;
        logic half_click;
    } dir_state_t;

    typedef struct packed {
        dir_state_t st;
        logic       click;
        logic       click_dir;
    } edge_result_t;

    // one committed edge; on_a is 1 for line A
    function automatic edge_result_t edge_step(dir_state_t s, logic on_a, logic other_level);
        edge_result_t r;
        logic         dir;
        dir         = (on_a == other_level);
        r.st        = s;
        r.click     = 1'b0;
        r.click_dir = dir;
        if (!s.dir_known || (s.last_direction != dir)) begin
            r.st.dir_known      = 1'b1;
            r.st.last_direction = dir;
            r.st.last_edge_line = on_a;
            r.st.half_click     = 1'b1;
        end
        else if (s.last_edge_line != on_a) begin
            r.st.last_edge_line = on_a;
            r.st.half_click     = !s.half_click;
            r.click             = s.half_click;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/rotary_encoder_click_decoder_core.sv
`default_nettype none
`include "rotary_encoder_click_decoder_core_macros.svh"

// Quadrature rotary encoder decoder with per-line debounce and a click queue.
// One transaction on the input channel carries one sample of lines A and B
// plus a pop request; each produces exactly one result transaction via the
// sample and result registers; a new sample can be taken each unstalled cycle.
// The figure of one sample per cycle is set by the state update loop: the
// debounce phases, the direction tracker and the click queue all move to
// their next value in one pass of logic between the sample register and the
// result register. The result register is a separate stage, so the input
// stalls only when a stalled result meets a full sample register. Each line, on
// going active from idle, commits an edge at once and then settles until its
// level has stayed unchanged for settle_ticks samples. Every second
// alternating edge in one direction makes one click; clicks of the same sign
// add into the newest queue entry (saturating at +/-127), and a new entry
// pushed onto a full queue drops the oldest one and raises dropped. The queue
// needs no clearing pass after reset. settle_ticks is written through the
// cfg port, which is always ready, and should only change while idle.
module rotary_encoder_click_decoder_core
    import recd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [SETTLE_W-1:0]       cfg_data,
    // samples
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      line_a_active,
    input  wire logic                      line_b_active,
    input  wire logic                      pop_request,
    // results
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           click_valid,
    output logic signed [COUNT_W-1:0]      click_count,
    output logic [QUEUED_W-1:0]            queued_entries,
    output logic                           dropped
);

    // settle_ticks register
    logic [SETTLE_W-1:0] settle_ticks_reg;

    // sample register
    logic item_valid_reg;
    logic line_a_reg;
    logic line_b_reg;
    logic pop_reg;

    // result register
    logic                      out_valid_reg;
    logic                      click_valid_reg;
    logic signed [COUNT_W-1:0] click_count_reg;
    logic [QUEUED_W-1:0]       queued_reg;
    logic                      dropped_reg;

    // block state
    phase_t              phase_reg  [2];
    phase_t              phase_next [2];
    logic                level_reg  [2];
    logic [SETTLE_W-1:0] settle_reg  [2];
    logic [SETTLE_W-1:0] settle_next [2];
    logic                edge_hit   [2];
    logic                level_now  [2];

    dir_state_t dir_reg;
    dir_state_t dir_next;

    logic signed [COUNT_W-1:0] queue_reg  [QUEUE_DEPTH];
    logic signed [COUNT_W-1:0] queue_next [QUEUE_DEPTH];
    logic signed [COUNT_W-1:0] after_push [QUEUE_DEPTH];
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;

    logic accept;
    logic advance;

    // handshakes: the sample stage moves on whenever the result stage is free
    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;

    assign level_now[0] = line_a_reg;
    assign level_now[1] = line_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            settle_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_a_reg <= line_a_active;
            line_b_reg <= line_b_active;
            pop_reg    <= pop_request;
        end
    end

    // ---------------------------------------------------------------
    // debounce: next phase per line
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [SETTLE_W-1:0] cnt;
        for (int i = 0; i < 2; i++)
        begin
            phase_next[i]  = phase_reg[i];
            settle_next[i] = settle_reg[i];
            cnt            = settle_reg[i];
            unique case (phase_reg[i])
                PH_IDLE:
                begin
                    if (level_now[i])
                    begin
                        phase_next[i]  = PH_SETTLE_ON;
                        settle_next[i] = '0;
                    end
                end
                PH_HELD:
                begin
                    if (!level_now[i])
                    begin
                        phase_next[i]  = PH_SETTLE_OFF;
                        settle_next[i] = '0;
                    end
                end
                PH_SETTLE_ON, PH_SETTLE_OFF:
                begin
                    if (level_now[i] != level_reg[i])
                    begin
                        cnt = '0;
                    end
                    else if (settle_reg[i] != SETTLE_MAX)
                    begin
                        cnt = settle_reg[i] + SETTLE_W'(1);
                    end
                    settle_next[i] = cnt;
                    if (cnt >= settle_ticks_reg)
                    begin
                        phase_next[i] = level_now[i] ? PH_HELD : PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next[i] = PH_IDLE;
                end
            endcase
        end
    end

    // debounce: edge commits, an idle line going active
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            edge_hit[i] = (phase_reg[i] == PH_IDLE) && level_now[i];
        end
    end

    // ---------------------------------------------------------------
    // direction tracking and click queue
    // ---------------------------------------------------------------
    edge_result_t edge_a;
    edge_result_t edge_b;
    dir_state_t   dir_mid;
    logic         click;
    logic         click_dir;

    always_comb
    begin
        edge_a  = edge_step(dir_reg, 1'b1, line_b_reg);
        dir_mid = edge_hit[0] ? edge_a.st : dir_reg;
        edge_b  = edge_step(dir_mid, 1'b0, line_a_reg);
        dir_next = edge_hit[1] ? edge_b.st : dir_mid;
        // a click is completed by the line A commit or the line B commit, never by both
        click     = (edge_hit[0] && edge_a.click) || (edge_hit[1] && edge_b.click);
        click_dir = (edge_hit[0] && edge_a.click) ? edge_a.click_dir : edge_b.click_dir;
    end

    logic [FILL_W-1:0]         fill_dec;
    logic [IDX_W-1:0]          tail_idx;
    logic signed [COUNT_W-1:0] tail_val;
    logic                      queue_full;
    logic                      merge;
    logic                      append;
    logic                      drop;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;
    logic signed [COUNT_W-1:0] wr_val;
    logic [FILL_W-1:0]         fill_push;
    logic                      pop_eff;

    assign fill_dec   = fill_reg - FILL_W'(1);
    assign tail_idx   = fill_dec[IDX_W-1:0];
    assign tail_val   = queue_reg[tail_idx];
    assign queue_full = (fill_reg == FILL_W'(QUEUE_DEPTH));
    // same sign as the newest entry merges into it
    assign merge      = click && (fill_reg != '0) && ((tail_val > 0) == click_dir);
    assign append     = click && !merge;
    assign drop       = append && queue_full;
    assign pop_eff    = pop_reg && (fill_push != '0);

    always_comb
    begin
        wr_en  = merge || append;
        wr_idx = tail_idx;
        wr_val = click_dir ? COUNT_UP : COUNT_DOWN;
        fill_push = fill_reg;
        priority if (merge)
        begin
            if (click_dir)
            begin
                wr_val = (tail_val < COUNT_MAX) ? tail_val + COUNT_UP : tail_val;
            end
            else
            begin
                wr_val = (tail_val > COUNT_MIN) ? tail_val - COUNT_UP : tail_val;
            end
        end
        else if (drop)
        begin
            wr_idx = IDX_W'(QUEUE_DEPTH - 1);
        end
        else if (append)
        begin
            wr_idx    = fill_reg[IDX_W-1:0];
            fill_push = fill_reg + FILL_W'(1);
        end
        else
        begin
            wr_en = 1'b0;
        end
        fill_next = pop_eff ? fill_push - FILL_W'(1) : fill_push;
    end

    // queue after the push, then after the pop; head always sits at entry 0
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            after_push[i] = drop ? queue_reg[i+1] : queue_reg[i];
        end
        after_push[QUEUE_DEPTH-1] = queue_reg[QUEUE_DEPTH-1];
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (wr_en && (wr_idx == IDX_W'(i)))
            begin
                after_push[i] = wr_val;
            end
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            queue_next[i] = pop_eff ? after_push[i+1] : after_push[i];
        end
        queue_next[QUEUE_DEPTH-1] = after_push[QUEUE_DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i]  <= PH_IDLE;
                level_reg[i]  <= 1'b0;
                settle_reg[i] <= '0;
            end
            dir_reg  <= '0;
            fill_reg <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i]  <= phase_next[i];
                level_reg[i]  <= level_now[i];
                settle_reg[i] <= settle_next[i];
            end
            dir_reg  <= dir_next;
            fill_reg <= fill_next;
        end
    end

    // queue entries and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            queue_reg       <= queue_next;
            click_valid_reg <= pop_eff;
            click_count_reg <= pop_eff ? after_push[0] : '0;
            queued_reg      <= QUEUED_W'(fill_next);
            dropped_reg     <= drop;
        end
    end

    assign out_valid      = out_valid_reg;
    assign click_valid    = click_valid_reg;
    assign click_count    = click_count_reg;
    assign queued_entries = queued_reg;
    assign dropped        = dropped_reg;

    // checks
    `RECD_ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= FILL_W'(QUEUE_DEPTH))
    `RECD_ASSERT_IMPL(a_click_nonzero, clk, rst_n, out_valid_reg, click_valid_reg == (click_count_reg != '0))
    `RECD_ASSERT_IMPL(a_drop_full, clk, rst_n, out_valid_reg && dropped_reg, queued_reg == QUEUED_W'(QUEUE_DEPTH) || queued_reg == QUEUED_W'(QUEUE_DEPTH - 1))
    `RECD_ASSERT_NEXT(a_advance_result, clk, rst_n, advance, out_valid_reg)

endmodule

`default_nettype wire
